>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the timeout tracker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RTT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RTT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/rtt_pkg.sv
// ----------------------------------------------------------------------------
// rtt_pkg
// Types, codes and helper functions of the request timeout tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rtt_pkg;

   localparam int SLOTS_DEFAULT = 8;
   localparam int MASK_W        = 8;
   localparam int CSR_ADDR_W    = 4;

   localparam logic [31:0] RESET_TIMEOUT_MEASURE     = 32'd90000;
   localparam logic [31:0] RESET_TIMEOUT_CALIBRATE   = 32'd240000;
   localparam logic [31:0] RESET_TIMEOUT_HEALTHCHECK = 32'd15000;
   localparam logic [31:0] RESET_MARGIN              = 32'd15000;
   localparam logic [7:0]  EMPTY_RESULT              = 8'd2;

   // register indexes
   localparam logic [1:0] REG_TIMEOUT_MEASURE     = 2'd0;
   localparam logic [1:0] REG_TIMEOUT_CALIBRATE   = 2'd1;
   localparam logic [1:0] REG_TIMEOUT_HEALTHCHECK = 2'd2;
   localparam logic [1:0] REG_BROADCAST_MARGIN    = 2'd3;

   // command codes
   localparam logic [1:0] OPC_CALIBRATE   = 2'd0;
   localparam logic [1:0] OPC_MEASURE     = 2'd1;
   localparam logic [1:0] OPC_HEALTHCHECK = 2'd2;

   // response kinds
   localparam logic [1:0] KIND_MEASURE     = 2'd0;
   localparam logic [1:0] KIND_HEALTHCHECK = 2'd1;
   localparam logic [1:0] KIND_CALIBRATE   = 2'd2;
   localparam logic [1:0] KIND_OTHER       = 2'd3;

   typedef enum logic [1:0] {
      ACT_REQUEST   = 2'd0,
      ACT_BROADCAST = 2'd1,
      ACT_RESPONSE  = 2'd2,
      ACT_TICK      = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      EV_BC_PUBLISH      = 3'd0,
      EV_PENDING_PUBLISH = 3'd1,
      EV_UNSOLICITED     = 3'd2,
      EV_DROPPED         = 3'd3,
      EV_STORED          = 3'd4,
      EV_TABLE_FULL      = 3'd5,
      EV_WINDOW_OPENED   = 3'd6,
      EV_TICK            = 3'd7
   } event_type;

   typedef enum logic [1:0] {
      ALU_ADD        = 2'd0,
      ALU_EQ         = 2'd1,
      ALU_GT         = 2'd2,
      ALU_ELAPSED_GT = 2'd3
   } alu_op_type;

   typedef struct packed {
      logic [15:0] node;
      logic [1:0]  command;
      logic [31:0] sent;
   } slot_entry_type;

   typedef struct packed {
      logic write;
      logic set_active;
      logic clr_active;
   } slot_ctl_type;

   // fold the unused command code onto healthcheck
   function automatic logic [1:0] clamp_cmd(input logic [1:0] cmd);
      return (cmd > OPC_HEALTHCHECK) ? OPC_HEALTHCHECK : cmd;
   endfunction

   function automatic logic [1:0] kind_for_cmd(input logic [1:0] cmd);
      logic [1:0] kind;
      case (cmd)
         OPC_CALIBRATE: kind = KIND_CALIBRATE;
         OPC_MEASURE:   kind = KIND_MEASURE;
         default:       kind = KIND_HEALTHCHECK;
      endcase
      return kind;
   endfunction

   function automatic logic [1:0] cmd_for_kind(input logic [1:0] kind);
      logic [1:0] cmd;
      case (kind)
         KIND_MEASURE:     cmd = OPC_MEASURE;
         KIND_HEALTHCHECK: cmd = OPC_HEALTHCHECK;
         default:          cmd = OPC_CALIBRATE;
      endcase
      return cmd;
   endfunction

   function automatic logic [31:0] limit_for(input logic [1:0]  cmd,
                                             input logic [31:0] t_measure,
                                             input logic [31:0] t_calibrate,
                                             input logic [31:0] t_health);
      logic [31:0] lim;
      case (cmd)
         OPC_MEASURE:   lim = t_measure;
         OPC_CALIBRATE: lim = t_calibrate;
         default:       lim = t_health;
      endcase
      return lim;
   endfunction

endpackage

>>> hw/rtl/rtt_alu.sv
// ----------------------------------------------------------------------------
// rtt_alu
// Shared 32-bit add / compare unit driven by the tracker sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtt_alu (
   input  rtt_pkg::alu_op_type op,
   input  logic [31:0]         a,
   input  logic [31:0]         b,
   input  logic [31:0]         c,
   output logic [31:0]         sum,
   output logic                flag
);

   logic [31:0] diff;

   assign diff = a - b;

   always_comb begin
      sum  = a + b;
      flag = 1'b0;
      unique case (op)
         rtt_pkg::ALU_ADD:        flag = 1'b0;
         rtt_pkg::ALU_EQ:         flag = (a == b);
         rtt_pkg::ALU_GT:         flag = (a > b);
         rtt_pkg::ALU_ELAPSED_GT: flag = (diff > c);
         default:                 flag = 1'b0;
      endcase
   end

endmodule

>>> hw/rtl/rtt_slot_table.sv
// ----------------------------------------------------------------------------
// rtt_slot_table
// Slot memory (node, command, send time) with per-slot active flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rtt_slot_table #(
   parameter int SLOTS = rtt_pkg::SLOTS_DEFAULT,
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [IDX_W-1:0]        index,
   input  rtt_pkg::slot_ctl_type   ctl,
   input  rtt_pkg::slot_entry_type wr_entry,
   output rtt_pkg::slot_entry_type rd_entry,
   output logic [SLOTS-1:0]        active
);

   rtt_pkg::slot_entry_type mem [SLOTS];
   rtt_pkg::slot_entry_type rd_entry_ff;
   logic [SLOTS-1:0]        active_ff;
   logic [SLOTS-1:0]        active_in;

   always_ff @(posedge clock) begin
      if (ctl.write) begin
         mem[index] <= wr_entry;
      end
      rd_entry_ff <= mem[index];
   end

   always_comb begin
      active_in = active_ff;
      if (ctl.set_active) begin
         active_in[index] = 1'b1;
      end
      if (ctl.clr_active) begin
         active_in[index] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else begin
         active_ff <= active_in;
      end
   end

   assign rd_entry = rd_entry_ff;
   assign active   = active_ff;

   `RTT_ASSERT_IMP(a_write_free_slot, clock, reset, ctl.write, !active_ff[index],
                   "slot written while still active")

endmodule

>>> hw/rtl/request_timeout_tracker.sv
// Steps: a response hitting the open window publishes in the next cycle; a broadcast runs
//   S_BC_SUM, S_BC_MARGIN; requests, other responses and ticks scan the slots one at a time
//   (ticks then end in S_WIN); the slot memory is single-port and the 32-bit ALU is shared.
// Throughput: one transaction at a time, start taken only while busy is low.
// Reset (synchronous): clears slot flags, window, time and sequencer; registers take
//   their defaults. Results are one-cycle strobes; the receiver cannot stall.
// ----------------------------------------------------------------------------
// request_timeout_tracker
// Outstanding-request table with timeouts and one broadcast window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module request_timeout_tracker #(
   parameter int SLOTS = rtt_pkg::SLOTS_DEFAULT,
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_action,
   input  logic [15:0]                   req_node,
   input  logic [1:0]                    req_command,
   input  logic [1:0]                    req_response_kind,
   input  logic                          req_has_payload,
   input  logic [7:0]                    req_payload_byte,
   // result channel
   output logic                          rsp_valid,
   output logic [2:0]                    rsp_event_res,
   output logic [15:0]                   rsp_source_node,
   output logic [1:0]                    rsp_original_command,
   output logic [7:0]                    rsp_result_code,
   output logic [7:0]                    rsp_expired_mask,
   output logic                          rsp_broadcast_closed,
   // configuration port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [rtt_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   // One-hot sequencer states
   typedef enum logic [9:0] {
      S_IDLE      = 10'b00_0000_0001,
      S_REQ_SCAN  = 10'b00_0000_0010,
      S_BC_SUM    = 10'b00_0000_0100,
      S_BC_MARGIN = 10'b00_0000_1000,
      S_RSP_READ  = 10'b00_0001_0000,
      S_RSP_EVAL  = 10'b00_0010_0000,
      S_TICK_INC  = 10'b00_0100_0000,
      S_TICK_READ = 10'b00_1000_0000,
      S_TICK_EVAL = 10'b01_0000_0000,
      S_WIN       = 10'b10_0000_0000
   } state_type;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [31:0] t_measure_ff, t_calibrate_ff, t_health_ff, margin_ff;
   logic        csr_write;
   logic [1:0]  csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         t_measure_ff   <= rtt_pkg::RESET_TIMEOUT_MEASURE;
         t_calibrate_ff <= rtt_pkg::RESET_TIMEOUT_CALIBRATE;
         t_health_ff    <= rtt_pkg::RESET_TIMEOUT_HEALTHCHECK;
         margin_ff      <= rtt_pkg::RESET_MARGIN;
      end else if (csr_write) begin
         unique case (csr_index)
            rtt_pkg::REG_TIMEOUT_MEASURE:     t_measure_ff   <= pwdata;
            rtt_pkg::REG_TIMEOUT_CALIBRATE:   t_calibrate_ff <= pwdata;
            rtt_pkg::REG_TIMEOUT_HEALTHCHECK: t_health_ff    <= pwdata;
            rtt_pkg::REG_BROADCAST_MARGIN:    margin_ff      <= pwdata;
            default:                          margin_ff      <= margin_ff;
         endcase
      end
   end

   // Read back the addressed register
   always_comb begin
      unique case (csr_index)
         rtt_pkg::REG_TIMEOUT_MEASURE:     prdata = t_measure_ff;
         rtt_pkg::REG_TIMEOUT_CALIBRATE:   prdata = t_calibrate_ff;
         rtt_pkg::REG_TIMEOUT_HEALTHCHECK: prdata = t_health_ff;
         rtt_pkg::REG_BROADCAST_MARGIN:    prdata = margin_ff;
         default:                          prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Sequencer and tracker state
   // ------------------------------------------------------------------
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   // latched transaction fields
   logic [15:0] r_node_ff, r_node_in;
   logic [1:0]  r_cmd_ff, r_cmd_in;
   logic [1:0]  r_kind_ff, r_kind_in;
   logic [7:0]  r_code_ff, r_code_in;

   // scratch for the two-step broadcast deadline sum, expiry mask of a tick
   logic [31:0] acc_ff, acc_in;
   logic [7:0]  mask_ff, mask_in;

   // time base and broadcast window
   logic [31:0] now_ff, now_in;
   logic        win_open_ff, win_open_in;
   logic [1:0]  win_cmd_ff, win_cmd_in;
   logic [31:0] win_deadline_ff, win_deadline_in;

   // result registers
   logic        out_valid_ff, out_valid_in;
   logic [2:0]  out_event_ff, out_event_in;
   logic [15:0] out_node_ff, out_node_in;
   logic [1:0]  out_cmd_ff, out_cmd_in;
   logic [7:0]  out_code_ff, out_code_in;
   logic [7:0]  out_mask_ff, out_mask_in;
   logic        out_closed_ff, out_closed_in;

   // shared ALU
   rtt_pkg::alu_op_type alu_op;
   logic [31:0]         alu_a, alu_b, alu_c, alu_sum;
   logic                alu_flag;

   // slot table
   rtt_pkg::slot_ctl_type   tbl_ctl;
   rtt_pkg::slot_entry_type tbl_wr_entry, tbl_rd_entry;
   logic [SLOTS-1:0]        tbl_active;

   logic       idx_last;
   logic [6:0] idx_ext;
   logic       miss_unsol;

   rtt_alu u_alu (
      .op   (alu_op),
      .a    (alu_a),
      .b    (alu_b),
      .c    (alu_c),
      .sum  (alu_sum),
      .flag (alu_flag)
   );

   rtt_slot_table #(
      .SLOTS (SLOTS)
   ) u_slot_table (
      .clock    (clock),
      .reset    (reset),
      .index    (idx_ff),
      .ctl      (tbl_ctl),
      .wr_entry (tbl_wr_entry),
      .rd_entry (tbl_rd_entry),
      .active   (tbl_active)
   );

   assign idx_last   = (idx_ff == LAST_IDX);
   assign idx_ext    = 7'(idx_ff);
   assign miss_unsol = (r_kind_ff != rtt_pkg::KIND_OTHER);

   // a new slot always records the current time
   assign tbl_wr_entry = '{node: r_node_ff, command: r_cmd_ff, sent: now_ff};

   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      r_node_in       = r_node_ff;
      r_cmd_in        = r_cmd_ff;
      r_kind_in       = r_kind_ff;
      r_code_in       = r_code_ff;
      acc_in          = acc_ff;
      mask_in         = mask_ff;
      now_in          = now_ff;
      win_open_in     = win_open_ff;
      win_cmd_in      = win_cmd_ff;
      win_deadline_in = win_deadline_ff;

      out_valid_in  = 1'b0;
      out_event_in  = out_event_ff;
      out_node_in   = out_node_ff;
      out_cmd_in    = out_cmd_ff;
      out_code_in   = out_code_ff;
      out_mask_in   = out_mask_ff;
      out_closed_in = out_closed_ff;

      alu_op  = rtt_pkg::ALU_ADD;
      alu_a   = '0;
      alu_b   = '0;
      alu_c   = '0;
      tbl_ctl = '0;

      unique case (state_ff) inside
         S_IDLE: begin
            if (start) begin
               r_node_in = req_node;
               r_cmd_in  = rtt_pkg::clamp_cmd(req_command);
               r_kind_in = req_response_kind;
               r_code_in = req_has_payload ? req_payload_byte : rtt_pkg::EMPTY_RESULT;
               idx_in    = '0;
               unique case (rtt_pkg::action_type'(req_action))
                  rtt_pkg::ACT_REQUEST:   state_in = S_REQ_SCAN;
                  rtt_pkg::ACT_BROADCAST: state_in = S_BC_SUM;
                  rtt_pkg::ACT_RESPONSE: begin
                     // open window answered: publish right away
                     if (win_open_ff &&
                         req_response_kind == rtt_pkg::kind_for_cmd(win_cmd_ff)) begin
                        out_valid_in  = 1'b1;
                        out_event_in  = rtt_pkg::EV_BC_PUBLISH;
                        out_node_in   = req_node;
                        out_cmd_in    = win_cmd_ff;
                        out_code_in   = req_has_payload ? req_payload_byte
                                                        : rtt_pkg::EMPTY_RESULT;
                        out_mask_in   = '0;
                        out_closed_in = 1'b0;
                     end else begin
                        state_in = S_RSP_READ;
                     end
                  end
                  rtt_pkg::ACT_TICK:      state_in = S_TICK_INC;
                  default:                state_in = S_IDLE;
               endcase
            end
         end

         S_REQ_SCAN: begin
            // take the lowest free slot, else report a full table
            if (!tbl_active[idx_ff]) begin
               tbl_ctl.write      = 1'b1;
               tbl_ctl.set_active = 1'b1;
               out_valid_in  = 1'b1;
               out_event_in  = rtt_pkg::EV_STORED;
               out_node_in   = r_node_ff;
               out_cmd_in    = r_cmd_ff;
               out_code_in   = '0;
               out_mask_in   = '0;
               out_closed_in = 1'b0;
               state_in      = S_IDLE;
            end else if (idx_last) begin
               out_valid_in  = 1'b1;
               out_event_in  = rtt_pkg::EV_TABLE_FULL;
               out_node_in   = r_node_ff;
               out_cmd_in    = r_cmd_ff;
               out_code_in   = '0;
               out_mask_in   = '0;
               out_closed_in = 1'b0;
               state_in      = S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         S_BC_SUM: begin
            alu_op   = rtt_pkg::ALU_ADD;
            alu_a    = now_ff;
            alu_b    = rtt_pkg::limit_for(r_cmd_ff, t_measure_ff, t_calibrate_ff,
                                          t_health_ff);
            acc_in   = alu_sum;
            state_in = S_BC_MARGIN;
         end

         S_BC_MARGIN: begin
            // reopen overwrites any window still running
            alu_op          = rtt_pkg::ALU_ADD;
            alu_a           = acc_ff;
            alu_b           = margin_ff;
            win_open_in     = 1'b1;
            win_cmd_in      = r_cmd_ff;
            win_deadline_in = alu_sum;
            out_valid_in    = 1'b1;
            out_event_in    = rtt_pkg::EV_WINDOW_OPENED;
            out_node_in     = '0;
            out_cmd_in      = r_cmd_ff;
            out_code_in     = '0;
            out_mask_in     = '0;
            out_closed_in   = 1'b0;
            state_in        = S_IDLE;
         end

         S_RSP_READ, S_TICK_READ: begin
            // skip idle slots; fetch active ones from the slot memory
            if (tbl_active[idx_ff]) begin
               state_in = (state_ff == S_RSP_READ) ? S_RSP_EVAL : S_TICK_EVAL;
            end else if (!idx_last) begin
               idx_in = idx_ff + 1'b1;
            end else if (state_ff == S_TICK_READ) begin
               state_in = S_WIN;
            end else begin
               out_valid_in  = 1'b1;
               out_event_in  = miss_unsol ? rtt_pkg::EV_UNSOLICITED : rtt_pkg::EV_DROPPED;
               out_node_in   = r_node_ff;
               out_cmd_in    = miss_unsol ? rtt_pkg::cmd_for_kind(r_kind_ff) : 2'd0;
               out_code_in   = miss_unsol ? r_code_ff : 8'd0;
               out_mask_in   = '0;
               out_closed_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         S_RSP_EVAL: begin
            alu_op = rtt_pkg::ALU_EQ;
            alu_a  = 32'(tbl_rd_entry.node);
            alu_b  = 32'(r_node_ff);
            if (alu_flag) begin
               // free the pending slot and publish its result
               tbl_ctl.clr_active = 1'b1;
               out_valid_in  = 1'b1;
               out_event_in  = rtt_pkg::EV_PENDING_PUBLISH;
               out_node_in   = r_node_ff;
               out_cmd_in    = tbl_rd_entry.command;
               out_code_in   = r_code_ff;
               out_mask_in   = '0;
               out_closed_in = 1'b0;
               state_in      = S_IDLE;
            end else if (idx_last) begin
               out_valid_in  = 1'b1;
               out_event_in  = miss_unsol ? rtt_pkg::EV_UNSOLICITED : rtt_pkg::EV_DROPPED;
               out_node_in   = r_node_ff;
               out_cmd_in    = miss_unsol ? rtt_pkg::cmd_for_kind(r_kind_ff) : 2'd0;
               out_code_in   = miss_unsol ? r_code_ff : 8'd0;
               out_mask_in   = '0;
               out_closed_in = 1'b0;
               state_in      = S_IDLE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_RSP_READ;
            end
         end

         S_TICK_INC: begin
            alu_op   = rtt_pkg::ALU_ADD;
            alu_a    = now_ff;
            alu_b    = 32'd1;
            now_in   = alu_sum;
            mask_in  = '0;
            state_in = S_TICK_READ;
         end

         S_TICK_EVAL: begin
            // wrap-safe elapsed time against the slot's own timeout
            alu_op = rtt_pkg::ALU_ELAPSED_GT;
            alu_a  = now_ff;
            alu_b  = tbl_rd_entry.sent;
            alu_c  = rtt_pkg::limit_for(tbl_rd_entry.command, t_measure_ff, t_calibrate_ff,
                                        t_health_ff);
            if (alu_flag) begin
               tbl_ctl.clr_active = 1'b1;
               if (idx_ext < 7'(rtt_pkg::MASK_W)) begin
                  mask_in[idx_ext[2:0]] = 1'b1;
               end
            end
            if (idx_last) begin
               state_in = S_WIN;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_TICK_READ;
            end
         end

         S_WIN: begin
            // plain unsigned deadline compare, no wrap handling
            alu_op        = rtt_pkg::ALU_GT;
            alu_a         = now_ff;
            alu_b         = win_deadline_ff;
            out_valid_in  = 1'b1;
            out_event_in  = rtt_pkg::EV_TICK;
            out_node_in   = '0;
            out_cmd_in    = '0;
            out_code_in   = '0;
            out_mask_in   = mask_ff;
            out_closed_in = win_open_ff && alu_flag;
            if (win_open_ff && alu_flag) begin
               win_open_in = 1'b0;
            end
            state_in = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         idx_ff          <= '0;
         now_ff          <= '0;
         win_open_ff     <= 1'b0;
         win_cmd_ff      <= rtt_pkg::OPC_HEALTHCHECK;
         win_deadline_ff <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         idx_ff          <= idx_in;
         now_ff          <= now_in;
         win_open_ff     <= win_open_in;
         win_cmd_ff      <= win_cmd_in;
         win_deadline_ff <= win_deadline_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      r_node_ff     <= r_node_in;
      r_cmd_ff      <= r_cmd_in;
      r_kind_ff     <= r_kind_in;
      r_code_ff     <= r_code_in;
      acc_ff        <= acc_in;
      mask_ff       <= mask_in;
      out_event_ff  <= out_event_in;
      out_node_ff   <= out_node_in;
      out_cmd_ff    <= out_cmd_in;
      out_code_ff   <= out_code_in;
      out_mask_ff   <= out_mask_in;
      out_closed_ff <= out_closed_in;
   end

   assign busy                 = (state_ff != S_IDLE);
   assign rsp_valid            = out_valid_ff;
   assign rsp_event_res        = out_event_ff;
   assign rsp_source_node      = out_node_ff;
   assign rsp_original_command = out_cmd_ff;
   assign rsp_result_code      = out_code_ff;
   assign rsp_expired_mask     = out_mask_ff;
   assign rsp_broadcast_closed = out_closed_ff;

   // results only appear once the sequencer is back at rest
   `RTT_ASSERT_IMP(a_rsp_at_rest, clock, reset, rsp_valid, !busy,
                   "result strobe while sequencer busy")

   // every transaction but a response keeps the sequencer busy after acceptance
   `RTT_ASSERT_NXT(a_accept_busy, clock, reset,
                   start && !busy && (req_action != rtt_pkg::ACT_RESPONSE), busy,
                   "sequencer did not leave idle after accepting a transaction")

   // expiry mask and window-closed flag belong to tick results only
   `RTT_ASSERT_IMP(a_tick_fields, clock, reset,
                   rsp_valid && (rsp_event_res != rtt_pkg::EV_TICK),
                   (rsp_expired_mask == 8'd0) && !rsp_broadcast_closed,
                   "tick fields set on a non-tick result")

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the request timeout tracker. A queue-fed driver
// issues tracker transactions (requests, broadcasts, responses, ticks) with
// random gaps; a monitor compares every result strobe against a transaction
// level copy of the slot table, broadcast window and millisecond counter.
// Timeout registers are rewritten between phases: zero, all ones, small
// values that make slots expire quickly, and fully random values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   import rtt_pkg::*;

   localparam int NSLOT          = SLOTS_DEFAULT;
   // leave headroom on top of the worst tick scan
   localparam int SETTLE_CYCLES  = 2 * NSLOT + 24;
   localparam int WATCHDOG_LIMIT = 2000;
   // the command field can carry 3, which the tracker folds onto healthcheck
   localparam logic [1:0] CMD_SPARE = 2'd3;

   typedef struct {
      action_type  action;
      logic [15:0] node;
      logic [1:0]  command;
      logic [1:0]  kind;
      logic        has_payload;
      logic [7:0]  payload;
   } req_item_type;

   typedef struct {
      event_type   event_code;
      logic [15:0] node;
      logic [1:0]  command;
      logic [7:0]  code;
      logic [7:0]  mask;
      logic        closed;
   } outcome_type;

   // ---------------------------------------------------------------------
   // DUT hookup; every input starts at a known value
   // ---------------------------------------------------------------------
   logic                  clock;
   logic                  reset             = 1'b1;
   logic                  start             = 1'b0;
   logic                  busy;
   logic [1:0]            req_action        = '0;
   logic [15:0]           req_node          = '0;
   logic [1:0]            req_command       = '0;
   logic [1:0]            req_response_kind = '0;
   logic                  req_has_payload   = 1'b0;
   logic [7:0]            req_payload_byte  = '0;
   logic                  rsp_valid;
   logic [2:0]            rsp_event_res;
   logic [15:0]           rsp_source_node;
   logic [1:0]            rsp_original_command;
   logic [7:0]            rsp_result_code;
   logic [7:0]            rsp_expired_mask;
   logic                  rsp_broadcast_closed;
   logic                  psel              = 1'b0;
   logic                  penable           = 1'b0;
   logic                  pwrite            = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr             = '0;
   logic [31:0]           pwdata            = '0;
   logic [31:0]           prdata;
   logic                  pready;

   request_timeout_tracker u_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_action           (req_action),
      .req_node             (req_node),
      .req_command          (req_command),
      .req_response_kind    (req_response_kind),
      .req_has_payload      (req_has_payload),
      .req_payload_byte     (req_payload_byte),
      .rsp_valid            (rsp_valid),
      .rsp_event_res        (rsp_event_res),
      .rsp_source_node      (rsp_source_node),
      .rsp_original_command (rsp_original_command),
      .rsp_result_code      (rsp_result_code),
      .rsp_expired_mask     (rsp_expired_mask),
      .rsp_broadcast_closed (rsp_broadcast_closed),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Shadow of the tracker: slot table, broadcast window, time, registers
   // ---------------------------------------------------------------------
   logic        slot_busy  [NSLOT];
   logic [15:0] slot_owner [NSLOT];
   logic [1:0]  slot_cmd   [NSLOT];
   logic [31:0] slot_stamp [NSLOT];
   logic        bc_open     = 1'b0;
   logic [1:0]  bc_cmd      = OPC_HEALTHCHECK;
   logic [31:0] bc_deadline = '0;
   logic [31:0] clock_ms    = '0;
   logic [31:0] csr_shadow [4];

   initial begin
      foreach (slot_busy[i]) slot_busy[i] = 1'b0;
      csr_shadow[REG_TIMEOUT_MEASURE]     = RESET_TIMEOUT_MEASURE;
      csr_shadow[REG_TIMEOUT_CALIBRATE]   = RESET_TIMEOUT_CALIBRATE;
      csr_shadow[REG_TIMEOUT_HEALTHCHECK] = RESET_TIMEOUT_HEALTHCHECK;
      csr_shadow[REG_BROADCAST_MARGIN]    = RESET_MARGIN;
   end

   req_item_type stim_q[$];      // transactions waiting for the driver
   outcome_type  due_events[$];  // results owed by the tracker, oldest first
   req_item_type cur_item;
   outcome_type  head_event;
   int items_queued = 0;
   int items_taken  = 0;
   int fail_count   = 0;
   int quiet_cycles = 0;
   int gap_left     = 0;
   int burst_left   = 0;

   function automatic logic [31:0] timeout_of(input logic [1:0] cmd);
      case (cmd)
         OPC_MEASURE:   return csr_shadow[REG_TIMEOUT_MEASURE];
         OPC_CALIBRATE: return csr_shadow[REG_TIMEOUT_CALIBRATE];
         default:       return csr_shadow[REG_TIMEOUT_HEALTHCHECK];
      endcase
   endfunction

   // response kind that answers a given command
   function automatic logic [1:0] answer_kind(input logic [1:0] cmd);
      case (cmd)
         OPC_CALIBRATE: return KIND_CALIBRATE;
         OPC_MEASURE:   return KIND_MEASURE;
         default:       return KIND_HEALTHCHECK;
      endcase
   endfunction

   // command that a result kind answers (never called with the other kind)
   function automatic logic [1:0] asked_command(input logic [1:0] kind);
      case (kind)
         KIND_MEASURE:     return OPC_MEASURE;
         KIND_HEALTHCHECK: return OPC_HEALTHCHECK;
         default:          return OPC_CALIBRATE;
      endcase
   endfunction

   // Advance the shadow by one accepted transaction and queue its result.
   function automatic void update_table(input req_item_type it);
      outcome_type ev;
      logic [1:0]  cmd;
      logic [7:0]  code;
      logic [31:0] elapsed;
      int          hit;
      ev.event_code = EV_TICK;
      ev.node       = '0;
      ev.command    = '0;
      ev.code       = '0;
      ev.mask       = '0;
      ev.closed     = 1'b0;
      hit           = -1;
      cmd  = (it.command > OPC_HEALTHCHECK) ? OPC_HEALTHCHECK : it.command;
      code = it.has_payload ? it.payload : EMPTY_RESULT;
      case (it.action)
         ACT_REQUEST: begin
            // take the lowest free slot, else report the table as full
            for (int i = 0; i < NSLOT; i++) begin
               if (!slot_busy[i] && hit < 0) hit = i;
            end
            ev.node    = it.node;
            ev.command = cmd;
            if (hit >= 0) begin
               slot_busy[hit]  = 1'b1;
               slot_owner[hit] = it.node;
               slot_cmd[hit]   = cmd;
               slot_stamp[hit] = clock_ms;
               ev.event_code   = EV_STORED;
            end else begin
               ev.event_code = EV_TABLE_FULL;
            end
         end
         ACT_BROADCAST: begin
            // (re)open the window; the deadline wraps modulo 2^32
            bc_open       = 1'b1;
            bc_cmd        = cmd;
            bc_deadline   = clock_ms + timeout_of(cmd) + csr_shadow[REG_BROADCAST_MARGIN];
            ev.event_code = EV_WINDOW_OPENED;
            ev.command    = cmd;
         end
         ACT_RESPONSE: begin
            ev.node = it.node;
            if (bc_open && it.kind == answer_kind(bc_cmd)) begin
               ev.event_code = EV_BC_PUBLISH;
               ev.command    = bc_cmd;
               ev.code       = code;
            end else begin
               for (int i = 0; i < NSLOT; i++) begin
                  if (slot_busy[i] && slot_owner[i] == it.node && hit < 0) hit = i;
               end
               if (hit >= 0) begin
                  // free the lowest pending slot of that node, any kind
                  slot_busy[hit] = 1'b0;
                  ev.event_code  = EV_PENDING_PUBLISH;
                  ev.command     = slot_cmd[hit];
                  ev.code        = code;
               end else if (it.kind != KIND_OTHER) begin
                  ev.event_code = EV_UNSOLICITED;
                  ev.command    = asked_command(it.kind);
                  ev.code       = code;
               end else begin
                  ev.event_code = EV_DROPPED;
               end
            end
         end
         default: begin
            // tick: advance time first, then expire by wrap-safe elapsed time
            clock_ms = clock_ms + 32'd1;
            for (int i = 0; i < NSLOT; i++) begin
               elapsed = clock_ms - slot_stamp[i];
               if (slot_busy[i] && elapsed > timeout_of(slot_cmd[i])) begin
                  slot_busy[i] = 1'b0;
                  ev.mask[i]   = 1'b1;
               end
            end
            // window close is a plain unsigned compare, no wrap handling
            if (bc_open && clock_ms > bc_deadline) begin
               bc_open   = 1'b0;
               ev.closed = 1'b1;
            end
         end
      endcase
      due_events.push_back(ev);
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic void push_item(input action_type a, input logic [15:0] n,
                                     input logic [1:0] c, input logic [1:0] k,
                                     input logic hp, input logic [7:0] pb);
      req_item_type it;
      it.action      = a;
      it.node        = n;
      it.command     = c;
      it.kind        = k;
      it.has_payload = hp;
      it.payload     = pb;
      stim_q.push_back(it);
      items_queued++;
   endfunction

   // Random traffic around a small pool of nodes so that responses hit slots
   // and the table fills up; ticks are frequent so short timeouts expire.
   function automatic void queue_random(input int count);
      logic [15:0] pool [6];
      logic [15:0] nd;
      action_type  act;
      int          r;
      int          n;
      foreach (pool[i]) pool[i] = 16'($urandom_range(0, 16'hFFFF));
      for (n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 35)      act = ACT_TICK;
         else if (r < 60) act = ACT_REQUEST;
         else if (r < 68) act = ACT_BROADCAST;
         else             act = ACT_RESPONSE;
         if ($urandom_range(0, 9) == 0) nd = 16'($urandom_range(0, 16'hFFFF));
         else                           nd = pool[$urandom_range(0, 5)];
         push_item(act, nd, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                   ($urandom_range(0, 4) != 0), 8'($urandom_range(0, 255)));
      end
   endfunction

   // Mostly short gaps, a few long ones, and now and then a run with none.
   function automatic int pick_gap();
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         burst_left = $urandom_range(10, 40);
         return 0;
      end
      if (r < 40) return 0;
      if (r < 80) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 15);
      return $urandom_range(20, 80);
   endfunction

   // One APB transfer: setup cycle, then access until pready.
   task automatic csr_access(input logic is_write, input logic [1:0] idx,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      quiet_cycles = 0;
   endtask

   // Write a register, mirror it in the shadow, then read it back.
   task automatic set_reg(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] readback;
      csr_access(1'b1, idx, value, readback);
      csr_shadow[idx] = value;
      csr_access(1'b0, idx, '0, readback);
      if (readback !== value) begin
         $display("%0t ns: register %0d readback, expected 0x%0h, actual 0x%0h",
                  $time, idx, value, readback);
         fail_count++;
      end
   endtask

   task automatic program_all(input logic [31:0] t_measure, input logic [31:0] t_calibrate,
                              input logic [31:0] t_health, input logic [31:0] margin);
      set_reg(REG_TIMEOUT_MEASURE, t_measure);
      set_reg(REG_TIMEOUT_CALIBRATE, t_calibrate);
      set_reg(REG_TIMEOUT_HEALTHCHECK, t_health);
      set_reg(REG_BROADCAST_MARGIN, margin);
   endtask

   // Hold until every queued transaction is taken and every result is in,
   // then let the longest tick scan finish before touching registers.
   task automatic wait_idle();
      while (items_taken != items_queued || due_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Driver: present the next transaction, hold it while busy, then idle
   // for a random gap. Only one nonblocking write to start per edge.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            // transaction taken at this edge
            update_table(cur_item);
            items_taken++;
            quiet_cycles = 0;
            gap_left = pick_gap();
         end
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (stim_q.size() > 0) begin
               cur_item = stim_q.pop_front();
               req_action        <= cur_item.action;
               req_node          <= cur_item.node;
               req_command       <= cur_item.command;
               req_response_kind <= cur_item.kind;
               req_has_payload   <= cur_item.has_payload;
               req_payload_byte  <= cur_item.payload;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: every strobe must match the oldest owed result
   // ---------------------------------------------------------------------
   function automatic void check_field(input string label, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, label, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         quiet_cycles = 0;
         if (due_events.size() == 0) begin
            $display("%0t ns: result with nothing outstanding, event %0d node 0x%0h",
                     $time, rsp_event_res, rsp_source_node);
            fail_count++;
         end else begin
            head_event = due_events.pop_front();
            check_field("event_res", 32'(head_event.event_code), 32'(rsp_event_res));
            check_field("source_node", 32'(head_event.node), 32'(rsp_source_node));
            check_field("original_command", 32'(head_event.command),
                        32'(rsp_original_command));
            check_field("result_code", 32'(head_event.code), 32'(rsp_result_code));
            check_field("expired_mask", 32'(head_event.mask), 32'(rsp_expired_mask));
            check_field("broadcast_closed", 32'(head_event.closed),
                        32'(rsp_broadcast_closed));
         end
      end
   end

   // Watchdog: drop the run if nothing moves for too long.
   always @(posedge clock) begin
      if (!reset) begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sequence of phases
   // ---------------------------------------------------------------------
   initial begin
      int p;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset register values: table bookkeeping and response routing.
      push_item(ACT_TICK, 16'h0000, OPC_CALIBRATE, KIND_OTHER, 1'b0, 8'h00);
      push_item(ACT_REQUEST, 16'h0000, OPC_CALIBRATE, KIND_OTHER, 1'b0, 8'h00);
      push_item(ACT_REQUEST, 16'hFFFF, OPC_MEASURE, KIND_MEASURE, 1'b1, 8'hFF);
      // spare command code is stored as healthcheck
      push_item(ACT_REQUEST, 16'h5A5A, CMD_SPARE, KIND_OTHER, 1'b0, 8'h00);
      // same node twice: the lower slot must answer first
      push_item(ACT_REQUEST, 16'h0000, OPC_HEALTHCHECK, KIND_OTHER, 1'b0, 8'h00);
      push_item(ACT_RESPONSE, 16'hFFFF, CMD_SPARE, KIND_MEASURE, 1'b1, 8'hFF);
      // unmatched other kind is dropped; unmatched results are unsolicited
      push_item(ACT_RESPONSE, 16'h1234, OPC_CALIBRATE, KIND_OTHER, 1'b1, 8'h55);
      push_item(ACT_RESPONSE, 16'h4321, OPC_CALIBRATE, KIND_CALIBRATE, 1'b0, 8'hEE);
      push_item(ACT_RESPONSE, 16'h8001, OPC_MEASURE, KIND_HEALTHCHECK, 1'b1, 8'h00);
      push_item(ACT_RESPONSE, 16'h8002, OPC_HEALTHCHECK, KIND_MEASURE, 1'b1, 8'h7E);
      // window takes priority over a pending slot of the same node
      push_item(ACT_BROADCAST, 16'h0000, OPC_MEASURE, KIND_OTHER, 1'b0, 8'h00);
      push_item(ACT_RESPONSE, 16'h0000, OPC_CALIBRATE, KIND_MEASURE, 1'b1, 8'h81);
      push_item(ACT_RESPONSE, 16'h0000, OPC_CALIBRATE, KIND_CALIBRATE, 1'b1, 8'h3C);
      push_item(ACT_RESPONSE, 16'h0000, OPC_CALIBRATE, KIND_OTHER, 1'b0, 8'h00);
      // broadcast while open overwrites the window; spare code folds
      push_item(ACT_BROADCAST, 16'h0000, CMD_SPARE, KIND_OTHER, 1'b0, 8'h00);
      push_item(ACT_RESPONSE, 16'h5A5A, OPC_MEASURE, KIND_HEALTHCHECK, 1'b1, 8'hA5);
      push_item(ACT_BROADCAST, 16'hFFFF, OPC_CALIBRATE, KIND_OTHER, 1'b0, 8'h00);
      // fill every slot, then one more for table full
      for (p = 1; p <= 7; p++) begin
         push_item(ACT_REQUEST, 16'(16'h0100 + p), 2'(p % 3), KIND_OTHER, 1'b0, 8'h00);
      end
      push_item(ACT_REQUEST, 16'hBEEF, OPC_MEASURE, KIND_OTHER, 1'b0, 8'h00);
      push_item(ACT_TICK, 16'h0000, OPC_CALIBRATE, KIND_OTHER, 1'b0, 8'h00);
      wait_idle();

      // All zero: every slot expires on the next tick, window closes at once.
      program_all('0, '0, '0, '0);
      push_item(ACT_TICK, 16'h0000, OPC_CALIBRATE, KIND_OTHER, 1'b0, 8'h00);
      push_item(ACT_REQUEST, 16'h0011, OPC_CALIBRATE, KIND_OTHER, 1'b0, 8'h00);
      push_item(ACT_REQUEST, 16'h0022, OPC_MEASURE, KIND_OTHER, 1'b0, 8'h00);
      push_item(ACT_REQUEST, 16'h0033, OPC_HEALTHCHECK, KIND_OTHER, 1'b0, 8'h00);
      push_item(ACT_BROADCAST, 16'h0000, OPC_HEALTHCHECK, KIND_OTHER, 1'b0, 8'h00);
      push_item(ACT_TICK, 16'h0000, OPC_CALIBRATE, KIND_OTHER, 1'b0, 8'h00);
      push_item(ACT_RESPONSE, 16'h0011, OPC_CALIBRATE, KIND_CALIBRATE, 1'b1, 8'h11);
      queue_random(100);
      wait_idle();

      // All ones: slots never expire, the deadline wraps below now.
      program_all('1, '1, '1, '1);
      push_item(ACT_REQUEST, 16'hF0F0, OPC_MEASURE, KIND_OTHER, 1'b0, 8'h00);
      push_item(ACT_BROADCAST, 16'h0000, OPC_CALIBRATE, KIND_OTHER, 1'b0, 8'h00);
      push_item(ACT_TICK, 16'h0000, OPC_CALIBRATE, KIND_OTHER, 1'b0, 8'h00);
      push_item(ACT_TICK, 16'h0000, OPC_CALIBRATE, KIND_OTHER, 1'b0, 8'h00);
      push_item(ACT_RESPONSE, 16'hF0F0, OPC_CALIBRATE, KIND_HEALTHCHECK, 1'b1, 8'hC3);
      queue_random(100);
      wait_idle();

      // Short timeouts so expiry, window close and table full all recur.
      for (p = 0; p < 5; p++) begin
         program_all($urandom_range(0, 40), $urandom_range(0, 60),
                     $urandom_range(0, 20), $urandom_range(0, 30));
         queue_random(200);
         wait_idle();
      end

      // Full-range register values.
      program_all($urandom, $urandom, $urandom, $urandom);
      queue_random(150);
      wait_idle();

      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
